[hdl/tile_corner_to_lat_lon_top_assert.svh]
// Assertion macros shared by the tile corner checker.
`ifndef TILE_CORNER_TO_LAT_LON_TOP_ASSERT_SVH
`define TILE_CORNER_TO_LAT_LON_TOP_ASSERT_SVH

// Same-cycle implication, message given as a string literal.
`define TC2LL_AST_IMP(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, message given as a string literal.
`define TC2LL_AST_NEXT(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tc2ll_pkg.sv]
// Shared constants, types and angle table functions for the tile corner block.
package tc2ll_pkg;

    localparam int unsigned DW         = 64;
    localparam int unsigned Q_W        = 32;
    localparam int unsigned C_W        = 32;
    localparam int unsigned IDX_W      = 20;
    localparam int unsigned ZOOM_W     = 5;
    localparam int unsigned LAT_W      = 28;
    localparam int unsigned LON_W      = 29;
    localparam int unsigned QUO_W      = 28;
    localparam int unsigned REM_W      = 63;
    localparam int unsigned MAG_W      = 33;
    localparam int unsigned HYP_STEPS  = 34;
    localparam int unsigned CIRC_STEPS = 34;
    localparam int unsigned S_DATA_W   = 48;
    localparam int unsigned M_DATA_W   = 120;
    localparam int unsigned M_USER_W   = 1;
    localparam int unsigned DEF_MAX_ZOOM = 20;

    // stages inside one latitude lane
    localparam int unsigned LANE_LAT = 1 + HYP_STEPS + 3 + CIRC_STEPS + 2 + QUO_W + 1;

    localparam logic signed [30:0]      PI4_Q30     = 31'sh3243F6A9;
    localparam logic signed [DW-1:0]    ATAN_ONE    = 64'sh0C90FDAA22168C23;
    localparam logic [REM_W-1:0]        PI_Q32      = 63'd13493037705;
    localparam logic [REM_W-1:0]        HALF_PI_Q32 = 63'd6746518852;
    localparam logic signed [LON_W-1:0] HALF_TURN   = 29'sd188743680;

    // state carried beside the lanes
    typedef struct packed {
        logic                    vld;
        logic                    in_range;
        logic signed [LON_W-1:0] left_lon;
        logic signed [LON_W-1:0] right_lon;
    } side_t;

    // floor(2^e / dvs) by shift-subtract
    function automatic logic [63:0] pow2_div(input int e, input int dvs);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            if (rem >= 64'(dvs)) begin
                rem = rem - 64'(dvs);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) or atanh(2^-i) in Q.60 from the power series, atan(1) as a constant
    function automatic logic signed [63:0] cordic_angle(input int i, input bit hyp);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 e;
        sum = '0;
        if (!hyp && i == 0) begin
            return ATAN_ONE;
        end
        for (int k = 0; k < 61; k++) begin
            if (i * (2 * k + 1) <= 60) begin
                e = 60 - i * (2 * k + 1);
                term = $signed(pow2_div(e, 2 * k + 1));
                if (!hyp && k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // shift of hyperbolic cell n: 1..32 with 4 and 13 taken twice
    function automatic int unsigned hyp_shift(input int unsigned n);
        if (n <= 3) begin
            return n + 1;
        end else if (n <= 13) begin
            return n;
        end
        return n - 1;
    endfunction

endpackage

[hdl/tc2ll_hyp_cell.sv]
// One hyperbolic rotation step of the cosh/sinh chain.
module tc2ll_hyp_cell #(
    parameter int unsigned SHIFT = 1
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [tc2ll_pkg::DW-1:0]  x_in,
    input  logic signed [tc2ll_pkg::DW-1:0]  y_in,
    input  logic signed [tc2ll_pkg::DW-1:0]  z_in,
    output logic signed [tc2ll_pkg::DW-1:0]  x_out,
    output logic signed [tc2ll_pkg::DW-1:0]  y_out,
    output logic signed [tc2ll_pkg::DW-1:0]  z_out
);
    import tc2ll_pkg::*;

    localparam logic signed [DW-1:0] ANG = cordic_angle(SHIFT, 1'b1);

    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic signed [DW-1:0] x_next, y_next, z_next;

    // rotate toward zero residual angle
    always_comb begin
        if (z_in >= 0) begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - ANG;
        end else begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[hdl/tc2ll_circ_cell.sv]
// One circular vectoring step of the arctangent chain.
module tc2ll_circ_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [tc2ll_pkg::DW-1:0]  x_in,
    input  logic signed [tc2ll_pkg::DW-1:0]  y_in,
    input  logic signed [tc2ll_pkg::DW-1:0]  z_in,
    output logic signed [tc2ll_pkg::DW-1:0]  x_out,
    output logic signed [tc2ll_pkg::DW-1:0]  y_out,
    output logic signed [tc2ll_pkg::DW-1:0]  z_out
);
    import tc2ll_pkg::*;

    localparam logic signed [DW-1:0] ANG = cordic_angle(SHIFT, 1'b0);

    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic signed [DW-1:0] x_next, y_next, z_next;

    // drive y toward zero, accumulate the angle
    always_comb begin
        if (y_in >= 0) begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + ANG;
        end else begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[hdl/tc2ll_div_cell.sv]
// One restoring step of the division by pi in Q.32.
module tc2ll_div_cell #(
    parameter int unsigned K = 0
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [tc2ll_pkg::REM_W-1:0]       rem_in,
    input  logic [tc2ll_pkg::QUO_W-1:0]       quo_in,
    input  logic                              neg_in,
    output logic [tc2ll_pkg::REM_W-1:0]       rem_out,
    output logic [tc2ll_pkg::QUO_W-1:0]       quo_out,
    output logic                              neg_out
);
    import tc2ll_pkg::*;

    localparam logic [REM_W-1:0] DVS = PI_Q32 << K;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic             neg_reg;
    logic             ge;

    // subtract the shifted divisor when it fits, shift in the quotient bit
    always_comb begin
        ge       = (rem_in >= DVS);
        rem_next = ge ? (rem_in - DVS) : rem_in;
        quo_next = {quo_in[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            neg_reg <= neg_in;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign neg_out = neg_reg;

endmodule

[hdl/tc2ll_lat_lane.sv]
// Latitude lane: scaled row angle in, latitude in 2^-20 degree out.
module tc2ll_lat_lane (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [tc2ll_pkg::Q_W-1:0]    q_in,
    output logic signed [tc2ll_pkg::LAT_W-1:0]  lat_out
);
    import tc2ll_pkg::*;

    logic signed [DW-1:0] z0_reg;
    logic signed [DW-1:0] hx [0:HYP_STEPS];
    logic signed [DW-1:0] hy [0:HYP_STEPS];
    logic signed [DW-1:0] hz [0:HYP_STEPS];
    logic signed [DW-1:0] cx [0:CIRC_STEPS];
    logic signed [DW-1:0] cy [0:CIRC_STEPS];
    logic signed [DW-1:0] cz [0:CIRC_STEPS];
    logic [REM_W-1:0]     drem [0:QUO_W];
    logic [QUO_W-1:0]     dquo [0:QUO_W];
    logic                 dneg [0:QUO_W];

    logic signed [C_W-1:0] c_reg, s_reg;
    logic signed [DW-1:0]  x_rnd, y_rnd;
    logic signed [DW-1:0]  cc_reg, ss_reg, cs_reg;
    logic signed [DW-1:0]  sum_x_reg, sum_y_reg;
    logic signed [DW-1:0]  z_rnd;
    logic signed [35:0]    z32;
    logic signed [35:0]    z32_abs;
    logic [MAG_W-1:0]      mag_reg;
    logic                  mneg_reg;
    logic                  dneg_reg;
    logic [REM_W-1:0]      num_reg, num_next;
    logic [MAG_W+5:0]      mag45;
    logic signed [LAT_W-1:0] lat_reg, lat_next;

    // start angle n*pi/4 in Q.60
    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg <= DW'(q_in * PI4_Q30);
        end
    end

    assign hx[0] = 64'sh0000_0100_0000_0000;
    assign hy[0] = '0;
    assign hz[0] = z0_reg;

    // hyperbolic rotation chain
    for (genvar n = 0; n < HYP_STEPS; n++) begin : g_hyp
        tc2ll_hyp_cell #(.SHIFT(hyp_shift(n))) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (hx[n]),
            .y_in  (hy[n]),
            .z_in  (hz[n]),
            .x_out (hx[n+1]),
            .y_out (hy[n+1]),
            .z_out (hz[n+1])
        );
    end

    // round cosh and sinh to Q.30
    always_comb begin
        x_rnd = hx[HYP_STEPS] + 64'sd512;
        y_rnd = hy[HYP_STEPS] + 64'sd512;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg     <= x_rnd[C_W+9:10];
            s_reg     <= y_rnd[C_W+9:10];
            cc_reg    <= DW'(c_reg * c_reg);
            ss_reg    <= DW'(s_reg * s_reg);
            cs_reg    <= DW'(c_reg * s_reg);
            sum_x_reg <= cc_reg + ss_reg;
            sum_y_reg <= cs_reg <<< 1;
        end
    end

    assign cx[0] = sum_x_reg;
    assign cy[0] = sum_y_reg;
    assign cz[0] = '0;

    // arctangent chain
    for (genvar n = 0; n < CIRC_STEPS; n++) begin : g_circ
        tc2ll_circ_cell #(.SHIFT(n)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (cx[n]),
            .y_in  (cy[n]),
            .z_in  (cz[n]),
            .x_out (cx[n+1]),
            .y_out (cy[n+1]),
            .z_out (cz[n+1])
        );
    end

    // round half-angle to Q.32, split sign and magnitude
    always_comb begin
        z_rnd   = cz[CIRC_STEPS] + 64'sd134217728;
        z32     = z_rnd[63:28];
        z32_abs = (z32 < 0) ? -z32 : z32;
        mag45   = (MAG_W+6)'(mag_reg) * (MAG_W+6)'(45);
        num_next = REM_W'({mag45, 23'b0}) + HALF_PI_Q32;
    end

    // keep the sign in step with the scaled magnitude
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= z32_abs[MAG_W-1:0];
            mneg_reg <= (z32 < 0);
            num_reg  <= num_next;
            dneg_reg <= mneg_reg;
        end
    end

    assign drem[0] = num_reg;
    assign dquo[0] = '0;
    assign dneg[0] = dneg_reg;

    // division by pi, one quotient bit per cell
    for (genvar n = 0; n < QUO_W; n++) begin : g_div
        tc2ll_div_cell #(.K(QUO_W - 1 - n)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (drem[n]),
            .quo_in  (dquo[n]),
            .neg_in  (dneg[n]),
            .rem_out (drem[n+1]),
            .quo_out (dquo[n+1]),
            .neg_out (dneg[n+1])
        );
    end

    // apply the sign
    always_comb begin
        lat_next = dneg[QUO_W] ? -$signed(dquo[QUO_W]) : $signed(dquo[QUO_W]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_reg <= lat_next;
        end
    end

    assign lat_out = lat_reg;

endmodule

[hdl/tile_corner_to_lat_lon_top.sv]
// Top level of the tile corner to latitude and longitude block.
//
// Input channel s_*: one transfer carries tile_x, tile_y and zoom.
// Result channel m_*: one transfer per input carries the four corner
// coordinates in tdata and the in_range flag in tuser.
// Pipeline: one prep stage, 103 stages in each latitude lane and one
// output register lie between input transfer and result valid.
// Throughput: one item per cycle while the chain is not held; both latitude
// lanes run side by side as chains of CORDIC and divider cells, one step per cell.
// Longitudes are formed in the prep stage and ride a shift line beside
// the lanes.
// Reset clears the valid bits of the shift line and the output register;
// data registers are not reset.
// When the receiver stalls, the pipeline keeps advancing while its last
// stage is empty, so new items are taken while a result waits; once a
// finished item reaches the end the whole chain holds and s_tready drops.
// Out-of-range tiles and zooms above MAX_ZOOM give in_range 0 and zero
// coordinates.
module tile_corner_to_lat_lon_top #(
    parameter int unsigned MAX_ZOOM = tc2ll_pkg::DEF_MAX_ZOOM
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tile_x[19:0], tile_y[39:20], zoom[44:40], zero pad
    input  logic [tc2ll_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // top_lat[27:0], left_lon[56:28], bottom_lat[84:57], right_lon[113:85], zero pad
    output logic [tc2ll_pkg::M_DATA_W-1:0]    m_tdata,
    // in_range[0]
    output logic [tc2ll_pkg::M_USER_W-1:0]    m_tuser
);
    import tc2ll_pkg::*;

    logic [IDX_W-1:0]  tile_x, tile_y;
    logic [ZOOM_W-1:0] zoom;
    logic [IDX_W:0]    row_b, col_r;
    logic              en;
    side_t             side_reg [0:LANE_LAT];
    side_t             side_next;
    logic signed [Q_W-1:0] q_top_reg, q_bot_reg;
    logic signed [LAT_W-1:0] top_lat, bottom_lat;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg;
    logic                m_tvalid_reg;
    side_t               last;

    // scaled row angle: (2^zoom - 2*row) * 2^(30-zoom)
    function automatic logic signed [Q_W-1:0] row_q(input logic [IDX_W:0] row,
                                                    input logic [ZOOM_W-1:0] zm);
        logic signed [Q_W:0] d;
        logic signed [Q_W:0] sh;
        d  = (33'sd1 <<< zm) - $signed({11'b0, row, 1'b0});
        sh = d <<< (5'd30 - zm);
        return sh[Q_W-1:0];
    endfunction

    // rounded longitude of a column edge
    function automatic logic signed [LON_W-1:0] col_lon(input logic [IDX_W:0] col,
                                                        input logic [ZOOM_W-1:0] zm);
        logic [26:0] m45;
        logic [50:0] p;
        logic [50:0] rnd;
        m45 = 27'(col) * 27'd45;
        p   = {1'b0, m45, 23'b0};
        rnd = (zm != '0) ? (51'd1 << (zm - 5'd1)) : '0;
        p   = (p + rnd) >> zm;
        return $signed(p[LON_W-1:0]) - HALF_TURN;
    endfunction

    assign tile_x = s_tdata[19:0];
    assign tile_y = s_tdata[39:20];
    assign zoom   = s_tdata[44:40];
    assign row_b  = {1'b0, tile_y} + 21'd1;
    assign col_r  = {1'b0, tile_x} + 21'd1;

    assign last = side_reg[LANE_LAT];

    // advance unless a finished item is blocked at the output
    assign en       = !last.vld || !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // prep stage: range check and longitudes
    always_comb begin
        side_next.vld       = s_tvalid;
        side_next.in_range  = (32'(zoom) <= MAX_ZOOM) && ((tile_x >> zoom) == '0) &&
                              ((tile_y >> zoom) == '0);
        side_next.left_lon  = col_lon({1'b0, tile_x}, zoom);
        side_next.right_lon = col_lon(col_r, zoom);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_top_reg <= row_q({1'b0, tile_y}, zoom);
            q_bot_reg <= row_q(row_b, zoom);
        end
    end

    // shift line beside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LANE_LAT; k++) begin
                side_reg[k].vld <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= LANE_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    tc2ll_lat_lane u_top_lane (
        .aclk    (aclk),
        .en      (en),
        .q_in    (q_top_reg),
        .lat_out (top_lat)
    );

    tc2ll_lat_lane u_bot_lane (
        .aclk    (aclk),
        .en      (en),
        .q_in    (q_bot_reg),
        .lat_out (bottom_lat)
    );

    // pack result, zero when out of range
    always_comb begin
        if (last.in_range) begin
            m_tdata_next = {6'b0, last.right_lon, bottom_lat, last.left_lon, top_lat};
        end else begin
            m_tdata_next = '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && last.vld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && last.vld) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= last.in_range;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/tc2ll_checker.sv]
// Port checker for the tile corner block and its bind.
`include "tile_corner_to_lat_lon_top_assert.svh"

module tc2ll_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [tc2ll_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tc2ll_pkg::M_DATA_W-1:0]    m_tdata,
    input logic [tc2ll_pkg::M_USER_W-1:0]    m_tuser
);
    import tc2ll_pkg::*;

    // reset empties the result channel
    `TC2LL_AST_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid, "result valid after reset")

    // a stalled result holds
    `TC2LL_AST_NEXT(a_stall_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // empty output never blocks the input
    `TC2LL_AST_IMP(a_ready_empty, aclk, !aresetn, !m_tvalid, s_tready, "input blocked with empty output")

    // out-of-range results carry zero coordinates
    `TC2LL_AST_IMP(a_zero_out, aclk, !aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "out-of-range result not zero")

    // left edge lies west of right edge
    `TC2LL_AST_IMP(a_lon_order, aclk, !aresetn, m_tvalid && m_tuser[0], $signed(m_tdata[56:28]) < $signed(m_tdata[113:85]), "left longitude not below right")

endmodule

bind tile_corner_to_lat_lon_top tc2ll_checker u_tc2ll_checker (.*);

[test/tb_top.sv]
// Testbench for the tile corner to latitude and longitude block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY   = 105;
    localparam int unsigned WDOG_MAX  = 20000;
    localparam int unsigned N_RANDOM  = 1432;

    typedef struct packed {
        logic                    in_range;
        logic signed [27:0]      top_lat;
        logic signed [28:0]      left_lon;
        logic signed [27:0]      bottom_lat;
        logic signed [28:0]      right_lon;
    } corners_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [tc2ll_pkg::S_DATA_W-1:0]      s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [tc2ll_pkg::M_DATA_W-1:0]      m_tdata;
    logic [tc2ll_pkg::M_USER_W-1:0]      m_tuser;

    // idle percentages, changed per phase
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned hold_cycles = 0;

    corners_t    expected_corners[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    longint      atan_q60[34];
    longint      atanh_q60[33];

    tile_corner_to_lat_lon_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // power series for atan/atanh of 2^-i in Q.60
    function automatic longint angle_series(int i, bit alternate);
        longint sum;
        longint t;
        int     k;
        sum = 0;
        k = 0;
        while (i * (2 * k + 1) <= 60) begin
            t = longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
            sum = (alternate && k[0]) ? sum - t : sum + t;
            k++;
        end
        return sum;
    endfunction

    function automatic void rotate_hyp(inout longint x, inout longint y, inout longint z,
                                       input int i);
        longint dx;
        longint dy;
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
            x += dx; y += dy; z -= atanh_q60[i];
        end else begin
            x -= dx; y -= dy; z += atanh_q60[i];
        end
    endfunction

    // latitude of a row edge, 2^-20 degree
    function automatic longint edge_lat(longint row, int zm);
        longint x, y, z, c, s, cx, cy, cz, dx, dy, z32, r;
        longint unsigned mag;
        x = 64'sd1 <<< 40;
        y = 0;
        z = (((64'sd1 <<< zm) - 2 * row) * (64'sd1 <<< (30 - zm))) * 64'sh3243F6A9;
        for (int i = 1; i <= 32; i++) begin
            rotate_hyp(x, y, z, i);
            if (i == 4 || i == 13) rotate_hyp(x, y, z, i);
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        cx = c * c + s * s;
        cy = 2 * c * s;
        cz = 0;
        for (int i = 0; i < 34; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; cz += atan_q60[i];
            end else begin
                cx -= dx; cy += dy; cz -= atan_q60[i];
            end
        end
        z32 = (cz + (64'sd1 <<< 27)) >>> 28;
        mag = (z32 < 0) ? -z32 : z32;
        r = longint'((mag * (64'd360 << 20) + 64'd13493037705 / 2) / 64'd13493037705);
        return (z32 < 0) ? -r : r;
    endfunction

    function automatic longint edge_lon(longint unsigned col, int zm);
        longint unsigned p;
        p = col * (64'd360 << 20);
        if (zm > 0) p = (p + (64'd1 << (zm - 1))) >> zm;
        return longint'(p) - (longint'(180) <<< 20);
    endfunction

    function automatic corners_t predict_corners(logic [19:0] tx, logic [19:0] ty,
                                                 logic [4:0] zm);
        corners_t r;
        r = '0;
        if (zm <= 20 && tx < (64'd1 << zm) && ty < (64'd1 << zm)) begin
            r.in_range   = 1'b1;
            r.top_lat    = 28'(edge_lat(ty, zm));
            r.left_lon   = 29'(edge_lon(tx, zm));
            r.bottom_lat = 28'(edge_lat(longint'(ty) + 1, zm));
            r.right_lon  = 29'(edge_lon(longint'(tx) + 1, zm));
        end
        return r;
    endfunction

    // send one tile request and queue its expected corners
    task automatic send_tile(logic [19:0] tx, logic [19:0] ty, logic [4:0] zm);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, zm, ty, tx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_corners.push_back(predict_corners(tx, ty, zm));
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        corners_t want;
        corners_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[27:0], m_tdata[56:28], m_tdata[84:57], m_tdata[113:85]};
            if (expected_corners.size() == 0) begin
                $error("unexpected result transfer");
                error_count++;
            end else begin
                want = expected_corners.pop_front();
                if (got.in_range !== want.in_range) begin
                    $error("in_range exp %0d got %0d", want.in_range, got.in_range);
                    error_count++;
                end
                if (got.top_lat !== want.top_lat) begin
                    $error("top_lat exp %0d got %0d", want.top_lat, got.top_lat);
                    error_count++;
                end
                if (got.left_lon !== want.left_lon) begin
                    $error("left_lon exp %0d got %0d", want.left_lon, got.left_lon);
                    error_count++;
                end
                if (got.bottom_lat !== want.bottom_lat) begin
                    $error("bottom_lat exp %0d got %0d", want.bottom_lat, got.bottom_lat);
                    error_count++;
                end
                if (got.right_lon !== want.right_lon) begin
                    $error("right_lon exp %0d got %0d", want.right_lon, got.right_lon);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_off <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            hold_off <= 1'b0;
        end
    end

    task automatic test_directed();
        send_tile(0, 0, 0);
        send_tile(1, 0, 0);
        send_tile(0, 1, 0);
        send_tile(0, 0, 1);
        send_tile(1, 1, 1);
        send_tile(2, 0, 1);
        send_tile(20'hFFFFF, 20'hFFFFF, 20);
        send_tile(0, 20'hFFFFF, 20);
        send_tile(20'hFFFFF, 0, 20);
        send_tile(0, 0, 20);
        send_tile(20'hFFFFF, 20'hFFFFF, 19);
        send_tile(5, 5, 21);
        send_tile(0, 0, 31);
        send_tile(20'hFFFFF, 20'hFFFFF, 31);
        send_tile(127, 64, 7);
        send_tile(128, 0, 7);
        send_tile(3, 4, 3);
        send_tile(20'h55555, 20'hAAAAA, 20);
        send_tile(20'hAAAAA, 20'h55555, 20);
    endtask

    task automatic random_tile();
        logic [4:0]  zm;
        logic [19:0] tx;
        logic [19:0] ty;
        int unsigned lim;
        zm = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(20));
        lim = (zm > 20) ? 20'hFFFFF : ((1 << zm) - 1);
        tx = 20'($urandom_range(lim));
        ty = 20'($urandom_range(lim));
        if ($urandom_range(15) == 0) tx = 20'($urandom());
        if ($urandom_range(15) == 0) ty = 20'($urandom());
        send_tile(tx, ty, zm);
    endtask

    task automatic test_random_phase(int unsigned n, int unsigned src_pct, int unsigned snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        for (int unsigned k = 0; k < n; k++) random_tile();
        src_idle_pct = 0;
    endtask

    task automatic test_backpressure_fill();
        snk_stall_pct = 0;
        hold_cycles = 400;
        for (int k = 0; k < 200; k++) random_tile();
    endtask

    initial begin
        for (int i = 0; i < 34; i++) atan_q60[i] = (i == 0) ? 64'sh0C90FDAA22168C23
                                                            : angle_series(i, 1'b1);
        atanh_q60[0] = 0;
        for (int i = 1; i <= 32; i++) atanh_q60[i] = angle_series(i, 1'b0);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(N_RANDOM / 4, 0, 0);
        test_random_phase(N_RANDOM / 4, 68, 0);
        test_random_phase(N_RANDOM / 4, 0, 68);
        test_random_phase(N_RANDOM / 4, 29, 29);
        test_backpressure_fill();
        s_tvalid <= 1'b0;
        snk_stall_pct = 0;
        while (expected_corners.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[tile_corner_to_lat_lon_top.f]
+incdir+hdl
hdl/tc2ll_pkg.sv
hdl/tc2ll_hyp_cell.sv
hdl/tc2ll_circ_cell.sv
hdl/tc2ll_div_cell.sv
hdl/tc2ll_lat_lane.sv
hdl/tile_corner_to_lat_lon_top.sv
hdl/tc2ll_checker.sv
test/tb_top.sv
